### hw/rtl/nfc_fr_pkg.sv
package nfc_fr_pkg;

  // Largest accepted LEN and the payload store geometry
  localparam int unsigned MaxPayload = 64;
  localparam int unsigned StoreDepth = 64;
  localparam int unsigned StoreAw    = 6;

  // Input item kinds
  localparam logic KindByte    = 1'b0;
  localparam logic KindTimeout = 1'b1;

  // Frame delimiters
  localparam logic [7:0] ByteZero = 8'h00;
  localparam logic [7:0] ByteFf   = 8'hFF;

  // Result status codes
  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StBadStart = 3'd1;
  localparam logic [2:0] StLcs      = 3'd2;
  localparam logic [2:0] StTooLong  = 3'd3;
  localparam logic [2:0] StDcs      = 3'd4;
  localparam logic [2:0] StPost     = 3'd5;
  localparam logic [2:0] StZeroLen  = 3'd6;
  localparam logic [2:0] StTimeout  = 3'd7;

  typedef struct packed {
    logic       kind;
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] payload_byte;
    logic [5:0] byte_index;
    logic [6:0] payload_length;
    logic       last;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic       ld_len;
    logic       clr_cnt;
    logic       wr_data;
    logic       ld_skip;
    logic       dec_skip;
    logic       rd_start;
    logic       rd_issue;
    logic       emit_ok;
    logic       emit_err;
    logic [2:0] err_code;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic byte_zero;
    logic byte_ff;
    logic lcs_ok;
    logic too_long;
    logic data_done;
    logic dcs_ok;
    logic skip_last;
    logic drain_last;
    logic out_free;
  } dp_flags_t;

endpackage

### hw/rtl/nfc_fr_ram.sv
module nfc_fr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/nfc_fr_ctrl.sv
module nfc_fr_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  kind_i,
  output logic                  in_stall_o,
  input  nfc_fr_pkg::dp_flags_t flags_i,
  output nfc_fr_pkg::cmd_t      cmd_o
);

  typedef enum logic [3:0] {
    PhHunt,
    PhZero2,
    PhStart,
    PhLen,
    PhLcs,
    PhData,
    PhDcs,
    PhPost,
    PhSkip,
    PhRead,
    PhEmit
  } phase_e;

  phase_e phase_q, phase_d;
  logic   draining;
  logic   fire;

  assign draining   = (phase_q == PhRead) || (phase_q == PhEmit);
  // an accepted item may load the output register, so it must be free
  assign in_stall_o = draining || !flags_i.out_free;
  assign fire       = in_valid_i && !in_stall_o;

  always_comb begin
    phase_d = phase_q;
    cmd_o   = '0;
    if (fire && phase_q == PhSkip) begin
      cmd_o.dec_skip = 1'b1;
      if (flags_i.skip_last) begin
        cmd_o.emit_err = 1'b1;
        cmd_o.err_code = nfc_fr_pkg::StZeroLen;
        phase_d        = PhHunt;
      end
    end else if (fire && kind_i == nfc_fr_pkg::KindTimeout) begin
      cmd_o.emit_err = 1'b1;
      cmd_o.err_code = nfc_fr_pkg::StTimeout;
      phase_d        = PhHunt;
    end else if (fire) begin
      unique case (phase_q)
        PhHunt: begin
          if (flags_i.byte_zero) phase_d = PhZero2;
        end
        PhZero2: begin
          if (flags_i.byte_zero) begin
            phase_d = PhStart;
          end else begin
            cmd_o.emit_err = 1'b1;
            cmd_o.err_code = nfc_fr_pkg::StBadStart;
            phase_d        = PhHunt;
          end
        end
        PhStart: begin
          if (flags_i.byte_ff) begin
            phase_d = PhLen;
          end else begin
            cmd_o.emit_err = 1'b1;
            cmd_o.err_code = nfc_fr_pkg::StBadStart;
            phase_d        = PhHunt;
          end
        end
        PhLen: begin
          cmd_o.ld_len = 1'b1;
          if (flags_i.byte_zero) begin
            cmd_o.ld_skip = 1'b1;
            phase_d       = PhSkip;
          end else begin
            phase_d = PhLcs;
          end
        end
        PhLcs: begin
          priority if (!flags_i.lcs_ok) begin
            cmd_o.emit_err = 1'b1;
            cmd_o.err_code = nfc_fr_pkg::StLcs;
            phase_d        = PhHunt;
          end else if (flags_i.too_long) begin
            cmd_o.emit_err = 1'b1;
            cmd_o.err_code = nfc_fr_pkg::StTooLong;
            phase_d        = PhHunt;
          end else begin
            cmd_o.clr_cnt = 1'b1;
            phase_d       = PhData;
          end
        end
        PhData: begin
          cmd_o.wr_data = 1'b1;
          if (flags_i.data_done) phase_d = PhDcs;
        end
        PhDcs: begin
          if (flags_i.dcs_ok) begin
            phase_d = PhPost;
          end else begin
            cmd_o.emit_err = 1'b1;
            cmd_o.err_code = nfc_fr_pkg::StDcs;
            phase_d        = PhHunt;
          end
        end
        PhPost: begin
          if (flags_i.byte_zero) begin
            cmd_o.rd_start = 1'b1;
            phase_d        = PhRead;
          end else begin
            cmd_o.emit_err = 1'b1;
            cmd_o.err_code = nfc_fr_pkg::StPost;
            phase_d        = PhHunt;
          end
        end
        default: phase_d = PhHunt;
      endcase
    end else if (phase_q == PhRead) begin
      cmd_o.rd_issue = 1'b1;
      phase_d        = PhEmit;
    end else if (phase_q == PhEmit && flags_i.out_free) begin
      cmd_o.emit_ok = 1'b1;
      phase_d       = flags_i.drain_last ? PhHunt : PhRead;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
    end else begin
      phase_q <= phase_d;
    end
  end

endmodule

### hw/rtl/nfc_fr_dp.sv
module nfc_fr_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [7:0]            rx_byte_i,
  input  nfc_fr_pkg::cmd_t      cmd_i,
  output nfc_fr_pkg::dp_flags_t flags_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output nfc_fr_pkg::out_item_t out_item_o
);

  logic [7:0] frame_len_q;
  logic [6:0] taken_q;
  logic [7:0] sum_q;
  logic [1:0] skip_q;
  logic [5:0] drain_idx_q;
  logic       out_valid_q;
  nfc_fr_pkg::out_item_t out_q, out_d;

  logic [7:0] rd_data;
  logic [7:0] len_plus_byte;
  logic [7:0] sum_plus_byte;
  logic [7:0] taken_next;
  logic [6:0] drain_next;

  assign len_plus_byte = frame_len_q + rx_byte_i;
  assign sum_plus_byte = sum_q + rx_byte_i;
  assign taken_next    = {1'b0, taken_q} + 8'd1;
  assign drain_next    = {1'b0, drain_idx_q} + 7'd1;

  assign flags_o.byte_zero  = (rx_byte_i == nfc_fr_pkg::ByteZero);
  assign flags_o.byte_ff    = (rx_byte_i == nfc_fr_pkg::ByteFf);
  assign flags_o.lcs_ok     = (len_plus_byte == 8'd0);
  assign flags_o.too_long   = (frame_len_q > 8'(nfc_fr_pkg::MaxPayload));
  assign flags_o.data_done  = (taken_next >= frame_len_q);
  assign flags_o.dcs_ok     = (sum_plus_byte == 8'd0);
  assign flags_o.skip_last  = (skip_q == 2'd1);
  assign flags_o.drain_last = ({1'b0, drain_next} == frame_len_q);
  assign flags_o.out_free   = !out_valid_q || !out_stall_i;

  nfc_fr_ram #(
    .Width (8),
    .Depth (nfc_fr_pkg::StoreDepth)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (cmd_i.wr_data),
    .waddr_i (taken_q[nfc_fr_pkg::StoreAw-1:0]),
    .wdata_i (rx_byte_i),
    .re_i    (cmd_i.rd_issue),
    .raddr_i (drain_idx_q),
    .rdata_o (rd_data)
  );

  always_comb begin
    out_d = out_q;
    if (cmd_i.emit_err) begin
      out_d.status         = cmd_i.err_code;
      out_d.payload_byte   = '0;
      out_d.byte_index     = '0;
      out_d.payload_length = '0;
      out_d.last           = 1'b1;
    end else if (cmd_i.emit_ok) begin
      out_d.status         = nfc_fr_pkg::StOk;
      out_d.payload_byte   = rd_data;
      out_d.byte_index     = drain_idx_q;
      out_d.payload_length = frame_len_q[6:0];
      out_d.last           = flags_o.drain_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_len_q <= '0;
      taken_q     <= '0;
      sum_q       <= '0;
      skip_q      <= '0;
      drain_idx_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.ld_len) frame_len_q <= rx_byte_i;
      if (cmd_i.clr_cnt) begin
        taken_q <= '0;
        sum_q   <= '0;
      end else if (cmd_i.wr_data) begin
        taken_q <= taken_next[6:0];
        sum_q   <= sum_plus_byte;
      end
      if (cmd_i.ld_skip) begin
        skip_q <= 2'd3;
      end else if (cmd_i.dec_skip) begin
        skip_q <= skip_q - 2'd1;
      end
      if (cmd_i.rd_start) begin
        drain_idx_q <= '0;
      end else if (cmd_i.emit_ok) begin
        drain_idx_q <= drain_next[5:0];
      end
      if (cmd_i.emit_err || cmd_i.emit_ok) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

### hw/rtl/nfc_frame_receiver.sv
// Channel  | Dir | Handshake               | Beat
// ---------+-----+-------------------------+---------------------------------
// in       | in  | in_valid_i / in_stall_o | kind, rx_byte (one UART event)
// out      | out | out_valid_o/out_stall_i | status, payload_byte, byte_index,
//          |     |                         | payload_length, last
//
// Each input beat is parsed in the cycle it is taken; outside a drain, a beat is
// taken whenever the output register is free or being emptied in that cycle.
// A good frame ends in a drain of LEN result beats, each a store read, then an
// output register load; no input is taken during the drain.
// Reset is asynchronous, active low; it returns the parser to hunting.
// The payload store needs no clearing: only bytes of the current frame are read.
// Stalls on the output hold the result register and back-pressure the input.
module nfc_frame_receiver (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  nfc_fr_pkg::in_item_t  in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output nfc_fr_pkg::out_item_t out_item_o
);

  nfc_fr_pkg::cmd_t      cmd;
  nfc_fr_pkg::dp_flags_t flags;

  // Parser / drain sequencer
  nfc_fr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .kind_i     (in_item_i.kind),
    .in_stall_o (in_stall_o),
    .flags_i    (flags),
    .cmd_o      (cmd)
  );

  // Length / checksum registers, payload store and result register
  nfc_fr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_byte_i   (in_item_i.rx_byte),
    .cmd_i       (cmd),
    .flags_o     (flags),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // An error beat is always a lone, final, zero-payload result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != nfc_fr_pkg::StOk |->
      out_item_o.last && out_item_o.payload_length == 7'd0 &&
      out_item_o.payload_byte == 8'd0)
    else $error("error beat with payload or without last");

  // Good beats index within the accepted length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == nfc_fr_pkg::StOk |->
      out_item_o.payload_length != 7'd0 &&
      {1'b0, out_item_o.byte_index} < out_item_o.payload_length)
    else $error("payload beat index out of range");

  // Mid-drain, input stays held off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_item_o.status == nfc_fr_pkg::StOk &&
      !out_item_o.last |-> in_stall_o)
    else $error("input taken during payload drain");

  // Nothing is issued to the store read port while a byte is being written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.wr_data && cmd.rd_issue))
    else $error("store written and read together");

endmodule
